>>> hw/rtl/compare_distance_feature_marker_assert.svh
// Assertion macros for the compare distance feature marker.
// Each macro expects signals named clk and arst_n in the calling module.
`ifndef COMPARE_DISTANCE_FEATURE_MARKER_ASSERT_SVH
`define COMPARE_DISTANCE_FEATURE_MARKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDFM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDFM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cdfm_pkg.sv
// Shared types and constants for the compare distance feature marker.
// No dependencies.
package cdfm_pkg;

	localparam int MAP_BYTES_DEF  = 8192;
	localparam int SITE_COUNT_DEF = 65536;

	localparam int IN_TDATA_W  = 280;
	localparam int OUT_TDATA_W = 24;

	localparam logic [31:0] FMIX_C1 = 32'h85eb_ca6b;
	localparam logic [31:0] FMIX_C2 = 32'hc2b2_ae35;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIFF,
		ST_ABS,
		ST_LEN,
		ST_MUL1,
		ST_MUL2,
		ST_MIX,
		ST_QN,
		ST_RED,
		ST_RD0,
		ST_RD1,
		ST_WB1,
		ST_DONE
	} cdfm_state_t;

endpackage

>>> hw/rtl/compare_distance_feature_marker.sv
// Marked compares pass the hash stages and the bitmap accesses; solved ones skip them.
// A new item is taken only once the last result is loaded: a sequencer walks the hash
// stages and two read-modify-write accesses to the single bitmap memory.
// After reset the bitmap is set to all ones by a clearing pass over all MAP_BYTES bytes,
// during which s_tready stays low. Control registers reset asynchronously on arst_n.
// Depends on cdfm_pkg and compare_distance_feature_marker_assert.svh.
`include "compare_distance_feature_marker_assert.svh"

module compare_distance_feature_marker import cdfm_pkg::*; #(
	parameter int MAP_BYTES  = MAP_BYTES_DEF,
	parameter int SITE_COUNT = SITE_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// Fields from bit 0: site, width_bytes, a_lo, a_hi, b_lo, b_hi, zero fill.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// Fields from bit 0: solved, bit_difference, distance_bucket, newly_cleared, zero fill.
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int     MAP_BITS = MAP_BYTES * 8;
	localparam int     BYTE_AW  = $clog2(MAP_BYTES);
	localparam int     IDX_W    = BYTE_AW + 3;
	localparam longint MOD_RCP  = 64'h1_0000_0000 / longint'(MAP_BITS);
	localparam int     RCP_W    = $clog2(MOD_RCP + 1);
	localparam int     PROD_W   = 32 + RCP_W;
	localparam int     SITE_RCP = 65536 / SITE_COUNT;
	localparam int     SRCP_W   = $clog2(SITE_RCP + 1);
	localparam int     SPROD_W  = 16 + SRCP_W;

	function automatic logic [127:0] width_mask(input logic [4:0] w);
		logic [4:0]   wc;
		logic [127:0] m;
		wc = (w > 5'd16) ? 5'd16 : w;
		m = '0;
		for (int i = 0; i < 16; i++) begin
			m[i*8 +: 8] = (5'(i) < wc) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [7:0] ones128(input logic [127:0] x);
		logic [7:0] n;
		n = '0;
		for (int i = 0; i < 128; i++) begin
			n = n + 8'(x[i]);
		end
		return n;
	endfunction

	function automatic logic [7:0] bit_len128(input logic [127:0] x);
		logic [7:0] n;
		n = '0;
		for (int i = 0; i < 128; i++) begin
			if (x[i]) begin
				n = 8'(i + 1);
			end
		end
		return n;
	endfunction

	cdfm_state_t state_q, state_nx;

	logic [BYTE_AW-1:0] clr_q;

	logic [127:0] a_s1, b_s1;
	logic [15:0]  site_s1;
	logic         wide_s1, w4_s1;

	logic               eq_s2, wide_s2, w4_s2;
	logic [127:0]       x_s2;
	logic [128:0]       d_s2;
	logic [SPROD_W-1:0] sprod_s2;
	logic [15:0]        site_s2;

	logic         eq_s3, wide_s3, w4_s3;
	logic [7:0]   ham_s3;
	logic [127:0] dabs_s3;
	logic [16:0]  sqn_s3;
	logic [15:0]  site_s3;

	logic        eq_s4;
	logic [7:0]  ham_s4, bucket_s4;
	logic [15:0] site_s4;

	logic [31:0]       h1a_s5, h1b_s5;
	logic [31:0]       h2a_s6, h2b_s6;
	logic [31:0]       h3a_s7, h3b_s7;
	logic [PROD_W-1:0] pa_s7, pb_s7;
	logic [31:0]       h3a_s8, h3b_s8;
	logic [32:0]       qna_s8, qnb_s8;
	logic [IDX_W-1:0]  idx0_s9, idx1_s9;

	logic       fresh0_q;
	logic [7:0] wr0_q;
	logic [1:0] nb_q;

	logic       m_tvalid_q;
	logic       out_solved_q;
	logic [7:0] out_ham_q, out_bucket_q;
	logic [1:0] out_nb_q;

	logic [7:0]         mem [MAP_BYTES];
	logic [7:0]         rd_q;
	logic               mem_we;
	logic [BYTE_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]         mem_wdata;
	logic               out_load;

	logic [BYTE_AW-1:0] byte0, byte1;
	logic [2:0]         bit0, bit1;
	logic [7:0]         cur1;
	logic               fresh1;

	logic [127:0] in_a, in_b, in_mask;
	logic [4:0]   in_w;
	logic [31:0]  fa, fb, ma, mb;
	logic [63:0]  pm1a, pm1b, pm2a, pm2b;
	logic [16:0]  sred;
	logic [15:0]  site_red;
	logic [32:0]  ra_full, rb_full;
	logic [IDX_W:0] ra, rb;

	assign byte0 = idx0_s9[IDX_W-1:3];
	assign byte1 = idx1_s9[IDX_W-1:3];
	assign bit0  = idx0_s9[2:0];
	assign bit1  = idx1_s9[2:0];
	assign cur1  = (byte1 == byte0) ? wr0_q : rd_q;
	assign fresh1 = cur1[bit1];

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == BYTE_AW'(MAP_BYTES - 1)) state_nx = ST_IDLE;
			ST_IDLE:  if (s_tvalid) state_nx = ST_DIFF;
			ST_DIFF:  state_nx = ST_ABS;
			ST_ABS:   state_nx = ST_LEN;
			ST_LEN:   state_nx = eq_s3 ? ST_DONE : ST_MUL1;
			ST_MUL1:  state_nx = ST_MUL2;
			ST_MUL2:  state_nx = ST_MIX;
			ST_MIX:   state_nx = ST_QN;
			ST_QN:    state_nx = ST_RED;
			ST_RED:   state_nx = ST_RD0;
			ST_RD0:   state_nx = ST_RD1;
			ST_RD1:   state_nx = ST_WB1;
			ST_WB1:   state_nx = ST_DONE;
			ST_DONE:  if (!m_tvalid_q || m_tready) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = byte0;
		mem_wdata = 8'hff;
		mem_raddr = byte0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: s_tready = 1'b1;
			ST_RD1: begin
				mem_we    = 1'b1;
				mem_waddr = byte0;
				mem_wdata = rd_q & ~(8'd1 << bit0);
				mem_raddr = byte1;
			end
			ST_WB1: begin
				mem_we    = 1'b1;
				mem_waddr = byte1;
				mem_wdata = cur1 & ~(8'd1 << bit1);
			end
			ST_DONE: out_load = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) clr_q <= clr_q + BYTE_AW'(1);
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	assign in_w    = s_tdata[20:16];
	assign in_mask = width_mask(in_w);
	assign in_a    = {s_tdata[148:85], s_tdata[84:21]} & in_mask;
	assign in_b    = {s_tdata[276:213], s_tdata[212:149]} & in_mask;

	assign sred     = {1'b0, site_s3} - sqn_s3;
	assign site_red = (sred >= 17'(SITE_COUNT)) ? 16'(sred - 17'(SITE_COUNT)) : sred[15:0];

	assign fa   = {8'd0, site_s4, 8'(ham_s4 - 8'd1)};
	assign fb   = {8'd0, site_s4, 1'b1, 7'(bucket_s4 - 8'd1)};
	assign pm1a = 64'(fa ^ (fa >> 16)) * 64'(FMIX_C1);
	assign pm1b = 64'(fb ^ (fb >> 16)) * 64'(FMIX_C1);
	assign pm2a = 64'(h1a_s5 ^ (h1a_s5 >> 13)) * 64'(FMIX_C2);
	assign pm2b = 64'(h1b_s5 ^ (h1b_s5 >> 13)) * 64'(FMIX_C2);
	assign ma   = h2a_s6 ^ (h2a_s6 >> 16);
	assign mb   = h2b_s6 ^ (h2b_s6 >> 16);

	assign ra_full = {1'b0, h3a_s8} - qna_s8;
	assign rb_full = {1'b0, h3b_s8} - qnb_s8;
	assign ra      = ra_full[IDX_W:0];
	assign rb      = rb_full[IDX_W:0];

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_s1    <= in_a;
				b_s1    <= in_b;
				site_s1 <= s_tdata[15:0];
				wide_s1 <= (in_w > 5'd8);
				w4_s1   <= (in_w == 5'd4);
			end
			ST_DIFF: begin
				eq_s2    <= (a_s1 == b_s1);
				x_s2     <= a_s1 ^ b_s1;
				d_s2     <= {1'b0, a_s1} - {1'b0, b_s1};
				sprod_s2 <= SPROD_W'(site_s1) * SPROD_W'(SITE_RCP);
				site_s2  <= site_s1;
				wide_s2  <= wide_s1;
				w4_s2    <= w4_s1;
			end
			ST_ABS: begin
				eq_s3   <= eq_s2;
				ham_s3  <= ones128(x_s2);
				dabs_s3 <= (wide_s2 && d_s2[128]) ? (128'd0 - d_s2[127:0]) : d_s2[127:0];
				sqn_s3  <= 17'(sprod_s2[SPROD_W-1:16]) * 17'(SITE_COUNT);
				site_s3 <= site_s2;
				wide_s3 <= wide_s2;
				w4_s3   <= w4_s2;
			end
			ST_LEN: begin
				eq_s4   <= eq_s3;
				ham_s4  <= ham_s3;
				site_s4 <= site_red;
				if (wide_s3) bucket_s4 <= bit_len128(dabs_s3);
				else if (w4_s3) bucket_s4 <= 8'd65 - bit_len128({96'd0, dabs_s3[31:0]});
				else bucket_s4 <= 8'd65 - bit_len128({64'd0, dabs_s3[63:0]});
			end
			ST_MUL1: begin
				h1a_s5 <= pm1a[31:0];
				h1b_s5 <= pm1b[31:0];
			end
			ST_MUL2: begin
				h2a_s6 <= pm2a[31:0];
				h2b_s6 <= pm2b[31:0];
			end
			ST_MIX: begin
				h3a_s7 <= ma;
				h3b_s7 <= mb;
				pa_s7  <= PROD_W'(ma) * PROD_W'(MOD_RCP);
				pb_s7  <= PROD_W'(mb) * PROD_W'(MOD_RCP);
			end
			ST_QN: begin
				h3a_s8 <= h3a_s7;
				h3b_s8 <= h3b_s7;
				qna_s8 <= 33'(pa_s7[PROD_W-1:32]) * 33'(MAP_BITS);
				qnb_s8 <= 33'(pb_s7[PROD_W-1:32]) * 33'(MAP_BITS);
			end
			ST_RED: begin
				idx0_s9 <= (ra >= (IDX_W+1)'(MAP_BITS)) ?
					IDX_W'(ra - (IDX_W+1)'(MAP_BITS)) : ra[IDX_W-1:0];
				idx1_s9 <= (rb >= (IDX_W+1)'(MAP_BITS)) ?
					IDX_W'(rb - (IDX_W+1)'(MAP_BITS)) : rb[IDX_W-1:0];
			end
			ST_RD1: begin
				fresh0_q <= rd_q[bit0];
				wr0_q    <= rd_q & ~(8'd1 << bit0);
			end
			ST_WB1: nb_q <= 2'(fresh0_q) + 2'(fresh1);
			default: begin
			end
		endcase
		if (out_load) begin
			out_solved_q <= eq_s4;
			out_ham_q    <= eq_s4 ? 8'd0 : ham_s4;
			out_bucket_q <= eq_s4 ? 8'd0 : bucket_s4;
			out_nb_q     <= eq_s4 ? 2'd0 : nb_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_nb_q, out_bucket_q, out_ham_q, out_solved_q};

	`CDFM_ASSERT_IMP(a_solved_zero, m_tvalid && m_tdata[0], m_tdata[18:1] == 18'd0, "solved result carries nonzero metrics")
	`CDFM_ASSERT_IMP(a_metric_range, m_tvalid && !m_tdata[0], (m_tdata[8:1] != 8'd0) && (m_tdata[8:1] <= 8'd128) && (m_tdata[16:9] != 8'd0) && (m_tdata[16:9] <= 8'd128), "metric out of range on a marked result")
	`CDFM_ASSERT_IMP(a_idx_range, state_q == ST_RD0, (32'(idx0_s9) < 32'(MAP_BITS)) && (32'(idx1_s9) < 32'(MAP_BITS)), "bitmap index beyond map size")
	`CDFM_ASSERT_IMP(a_new_bits, m_tvalid, m_tdata[18:17] != 2'd3, "more than two new bits reported")
	`CDFM_ASSERT_NXT(a_accept_start, s_tvalid && s_tready, state_q == ST_DIFF, "accepted item did not start processing")

endmodule
